// ===== rtl/core/nka_pkg.sv =====
`timescale 1ns / 1ps

package nka_pkg;

  localparam int MAX_WIDTH    = 64;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WCNT_W       = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W        = 12;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int CFG_W_W    = 7;
  localparam int CFG_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int TYPE_W     = 2;
  localparam int KEY_W      = 8;
  localparam int TILE_W     = 8;
  localparam int IDX_W      = 18;
  localparam int WIDE_LIMIT = 3;
  localparam int LUT_DEPTH  = 1 << KEY_W;

  localparam int IN_FIELDS_W  = TYPE_W + KEY_W + TILE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = IDX_W + TILE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic {
    MODE_CELL  = 1'b0,
    MODE_TABLE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [TILE_W-1:0] tile;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic              above_v;
    logic [IDX_W-1:0]  above_idx;
    logic [TILE_W-1:0] above_tile;
    logic              self_v;
    logic [IDX_W-1:0]  self_idx;
    logic [TILE_W-1:0] self_tile;
  } res_pair_t;

endpackage

// ===== rtl/core/neighbour_key_autotiler.sv =====
`timescale 1ns / 1ps

// channel  | dir | word contents (low bit first)               | tlast        | tuser
// s_axis   | in  | terrain[2], table_index[8], table_value[8]  | -            | mode
// m_axis   | out | cell_index[18], tile[8]                     | last_of_item | -
// cfg      | in  | cfg_index 0 = map_width, 1 = map_height; write only
//
// One input word per cycle while s_axis_tready is high; a map cell's results go
// through line store read, lookup table read and output register to m_axis.
// Last-row cells past row 0 give two words, so the output port sets the rate there.
// Each word writes a line store or the lookup table; both are read on enable.
// rst is synchronous; the lookup table reads as zero until written, no clear pass.
// s_axis_tready drops only while the result stage cannot load the output buffer.

module neighbour_key_autotiler
  import nka_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // terrain, table_index, table_value
  input  logic                  s_axis_tuser,   // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // cell_index, tile
  output logic                  m_axis_tlast,   // last_of_item
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_W_W-1:0] map_width;
  logic [CFG_H_W-1:0] map_height;
  logic [WCNT_W-1:0]  w_eff;
  logic [COL_W-1:0]   w_last;
  logic [CFG_H_W-1:0] h_eff;
  logic [ROW_W-1:0]   h_last;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [IDX_W-1:0] row_base;
  logic [IDX_W-1:0] prev_base;

  logic               in_mode;
  logic [TYPE_W-1:0]  in_terrain;
  logic [KEY_W-1:0]   in_tbl_index;
  logic [TILE_W-1:0]  in_tbl_value;

  logic             en;
  logic             cell_acc;
  logic             tbl_acc;
  logic             emit_above;
  logic             emit_self;
  logic             border;
  logic [COL_W-1:0] col_east;

  logic [MAX_WIDTH-1:0] wide_flags;
  logic                 left_wide;

  logic              s1_valid;
  logic              s1_above;
  logic              s1_self;
  logic [TYPE_W-1:0] s1_terrain;
  logic [COL_W-1:0]  s1_col;
  logic              s1_border;
  logic              s1_above_wide;
  logic [IDX_W-1:0]  s1_idx_above;
  logic [IDX_W-1:0]  s1_idx_self;
  logic [TYPE_W-1:0] north;
  logic [TYPE_W-1:0] center;
  logic [TYPE_W-1:0] east;
  logic [TYPE_W-1:0] west;
  logic [KEY_W-1:0]  key;

  logic              s2_valid;
  logic              s2_above;
  logic              s2_self;
  logic [TYPE_W-1:0] s2_terrain;
  logic [COL_W-1:0]  s2_col;
  logic              s2_lut_ok;
  logic [TYPE_W-1:0] s2_center;
  logic [IDX_W-1:0]  s2_idx_above;
  logic [IDX_W-1:0]  s2_idx_self;
  logic [TILE_W-1:0] lut_data;
  logic [TILE_W-1:0] tile_above;
  logic              tile_wide;

  res_pair_t res;
  logic      can_load;

  assign in_mode      = s_axis_tuser;
  assign in_terrain   = s_axis_tdata[TYPE_W-1:0];
  assign in_tbl_index = s_axis_tdata[TYPE_W+KEY_W-1:TYPE_W];
  assign in_tbl_value = s_axis_tdata[IN_FIELDS_W-1:TYPE_W+KEY_W];

  always_comb begin
    if (map_width == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(map_width) > MAX_WIDTH) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(map_width);
    end
    if (map_height == '0) begin
      h_eff = CFG_H_W'(1);
    end else if (32'(map_height) > HEIGHT_LIMIT) begin
      h_eff = CFG_H_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = map_height;
    end
  end

  assign w_last = COL_W'(w_eff - WCNT_W'(1));
  assign h_last = ROW_W'(h_eff - CFG_H_W'(1));

  assign en            = !s2_valid || can_load;
  assign s_axis_tready = en;
  assign cell_acc      = s_axis_tvalid && en && (in_mode == MODE_CELL);
  assign tbl_acc       = s_axis_tvalid && en && (in_mode == MODE_TABLE);

  assign emit_above = (row_count != '0);
  assign emit_self  = (row_count == h_last);
  assign border     = (row_count == ROW_W'(1)) || (col_count == '0) || (col_count == w_last);
  assign col_east   = (col_count == COL_W'(MAX_WIDTH - 1)) ? '0 : col_count + COL_W'(1);

  // config and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= CFG_W_W'(64);
      map_height <= CFG_H_W'(64);
      col_count  <= '0;
      row_count  <= '0;
      row_base   <= '0;
      prev_base  <= '0;
    end else if (cfg_we && (cfg_index == REG_MAP_WIDTH || cfg_index == REG_MAP_HEIGHT)) begin
      if (cfg_index == REG_MAP_WIDTH) begin
        map_width <= cfg_data[CFG_W_W-1:0];
      end else begin
        map_height <= cfg_data;
      end
      col_count <= '0;
      row_count <= '0;
      row_base  <= '0;
    end else if (cell_acc) begin
      if (col_count == w_last) begin
        col_count <= '0;
        if (row_count == h_last) begin
          row_count <= '0;
          row_base  <= '0;
        end else begin
          row_count <= row_count + ROW_W'(1);
          prev_base <= row_base;
          row_base  <= row_base + IDX_W'(w_eff);
        end
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  nka_line_store u_line_store (
    .clk         (clk),
    .rd_en       (en),
    .rd_par      (row_count[0]),
    .rd_col      (col_count),
    .rd_col_east (col_east),
    .wr_en       (cell_acc),
    .wr_par      (row_count[0]),
    .wr_col      (col_count),
    .wr_data     (in_terrain),
    .north       (north),
    .center      (center),
    .east        (east)
  );

  // stage 1: line store data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= cell_acc && (emit_above || emit_self);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_above      <= emit_above;
      s1_self       <= emit_self;
      s1_terrain    <= in_terrain;
      s1_col        <= col_count;
      s1_border     <= border;
      s1_above_wide <= wide_flags[col_count];
      s1_idx_above  <= prev_base + IDX_W'(col_count);
      s1_idx_self   <= row_base + IDX_W'(col_count);
    end
  end

  // west neighbor is the center of the previous cell in the row
  always_ff @(posedge clk) begin
    if (en && s1_valid && s1_above) begin
      west <= center;
    end
  end

  assign key = {west, s1_terrain, east, north};

  nka_tile_lut u_tile_lut (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_acc),
    .wr_addr (in_tbl_index),
    .wr_data (in_tbl_value),
    .rd_en   (en),
    .rd_addr (key),
    .rd_data (lut_data)
  );

  // stage 2: tile decision
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_above     <= s1_above;
      s2_self      <= s1_self;
      s2_terrain   <= s1_terrain;
      s2_col       <= s1_col;
      s2_lut_ok    <= !s1_border && !s1_above_wide;
      s2_center    <= center;
      s2_idx_above <= s1_idx_above;
      s2_idx_self  <= s1_idx_self;
    end
  end

  assign tile_above = (s2_lut_ok && !left_wide) ? lut_data : TILE_W'(s2_center);
  assign tile_wide  = (tile_above > TILE_W'(WIDE_LIMIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_flags <= '0;
      left_wide  <= 1'b0;
    end else if (en && s2_valid && s2_above) begin
      wide_flags[s2_col] <= tile_wide;
      left_wide          <= tile_wide;
    end
  end

  always_comb begin
    res.above_v    = s2_above;
    res.above_idx  = s2_idx_above;
    res.above_tile = tile_above;
    res.self_v     = s2_self;
    res.self_idx   = s2_idx_self;
    res.self_tile  = TILE_W'(s2_terrain);
  end

  nka_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .load          (en && s2_valid),
    .res           (res),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_count <= w_last)
    else $error("column counter beyond row width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_count <= h_last)
    else $error("row counter beyond map height");

  a_row_base: assert property (@(posedge clk) disable iff (rst)
    (row_count != '0) |-> (row_base == prev_base + IDX_W'(w_eff)))
    else $error("row base out of step with previous row base");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !en) |=> (s2_valid && $stable(s2_idx_above) && $stable(s2_self)))
    else $error("result stage changed while stalled");

endmodule

// ===== rtl/core/nka_line_store.sv =====
`timescale 1ns / 1ps

module nka_line_store
  import nka_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic              rd_par,
  input  logic [COL_W-1:0]  rd_col,
  input  logic [COL_W-1:0]  rd_col_east,
  input  logic              wr_en,
  input  logic              wr_par,
  input  logic [COL_W-1:0]  wr_col,
  input  logic [TYPE_W-1:0] wr_data,
  output logic [TYPE_W-1:0] north,
  output logic [TYPE_W-1:0] center,
  output logic [TYPE_W-1:0] east
);

  // one row per parity; read-old on same-address write
  logic [TYPE_W-1:0] row0 [MAX_WIDTH];
  logic [TYPE_W-1:0] row1 [MAX_WIDTH];

  logic [TYPE_W-1:0] row0_a;
  logic [TYPE_W-1:0] row0_b;
  logic [TYPE_W-1:0] row1_a;
  logic [TYPE_W-1:0] row1_b;
  logic              par_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row0_a <= row0[rd_col];
      row0_b <= row0[rd_col_east];
    end
    if (wr_en && !wr_par) begin
      row0[wr_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row1_a <= row1[rd_col];
      row1_b <= row1[rd_col_east];
      par_q  <= rd_par;
    end
    if (wr_en && wr_par) begin
      row1[wr_col] <= wr_data;
    end
  end

  assign north  = par_q ? row1_a : row0_a;
  assign center = par_q ? row0_a : row1_a;
  assign east   = par_q ? row0_b : row1_b;

endmodule

// ===== rtl/core/nka_tile_lut.sv =====
`timescale 1ns / 1ps

module nka_tile_lut
  import nka_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [KEY_W-1:0]  wr_addr,
  input  logic [TILE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [KEY_W-1:0]  rd_addr,
  output logic [TILE_W-1:0] rd_data
);

  logic [TILE_W-1:0]    mem [LUT_DEPTH];
  logic [LUT_DEPTH-1:0] written;
  logic [TILE_W-1:0]    data_q;
  logic                 written_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (rd_en) begin
        written_q <= written[rd_addr];
      end
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = written_q ? data_q : '0;

endmodule

// ===== rtl/core/nka_out_buf.sv =====
`timescale 1ns / 1ps

module nka_out_buf
  import nka_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  res_pair_t             res,
  output logic                  can_load,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // cell_index, tile
  output logic                  m_axis_tlast    // last_of_item
);

  out_word_t   word0;
  out_word_t   word1;
  logic [1:0]  count;
  logic        pop;
  out_word_t   above_word;
  out_word_t   self_word;

  assign pop      = m_axis_tvalid && m_axis_tready;
  assign can_load = (count == 2'd0) || (count == 2'd1 && m_axis_tready);

  always_comb begin
    above_word.idx  = res.above_idx;
    above_word.tile = res.above_tile;
    above_word.last = !res.self_v;
    self_word.idx   = res.self_idx;
    self_word.tile  = res.self_tile;
    self_word.last  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= (res.above_v && res.self_v) ? 2'd2 : 2'd1;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word0 <= res.above_v ? above_word : self_word;
      word1 <= self_word;
    end else if (pop) begin
      word0 <= word1;
    end
  end

  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = OUT_DATA_W'({word0.tile, word0.idx});
  assign m_axis_tlast  = word0.last;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import nka_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 8;
  localparam int N_DIR       = 20;
  localparam int N_PHASE     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    mode_t             md;
    logic [TYPE_W-1:0] ter;
    logic [KEY_W-1:0]  kidx;
    logic [TILE_W-1:0] kval;
    logic              typed;
    logic [1:0]        nres;
    logic [IDX_W-1:0]  i0;
    logic [TILE_W-1:0] t0;
    logic [IDX_W-1:0]  i1;
    logic [TILE_W-1:0] t1;
  } dir_row_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  ia;
    logic [CFG_DATA_W-1:0] da;
    logic [CFG_IDX_W-1:0]  ib;
    logic [CFG_DATA_W-1:0] db;
    logic [8:0]            items;
    logic                  squeeze;
    logic                  quiet;
  } phase_t;

  // 4x4 map, terrain rows: 0 3 1 2 / 3 0 2 1 / 2 1 3 0 / 1 2 0 3
  // inner cell (1,1) keys to 0xDB (tile 0xFF), which then blocks (1,2) and (2,1);
  // (2,2) keys to 0x42 (tile 3), written mid-map
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{MODE_TABLE, 2'd3, 8'hDB, 8'hFF, 1'b1, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_TABLE, 2'd0, 8'h00, 8'h80, 1'b1, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_TABLE, 2'd2, 8'hFF, 8'h01, 1'b1, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd0, 8'hA5, 8'h5A, 1'b1, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd3, 8'hFF, 8'hFF, 1'b1, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd1, 8'h00, 8'h00, 1'b1, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd2, 8'h3C, 8'hC3, 1'b1, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd3, 8'h00, 8'h00, 1'b1, 2'd1, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd0, 8'h00, 8'h00, 1'b1, 2'd1, 18'd1,  8'd3, 18'd0,  8'd0},
    '{MODE_CELL,  2'd2, 8'h00, 8'h00, 1'b1, 2'd1, 18'd2,  8'd1, 18'd0,  8'd0},
    '{MODE_CELL,  2'd1, 8'h00, 8'h00, 1'b1, 2'd1, 18'd3,  8'd2, 18'd0,  8'd0},
    '{MODE_TABLE, 2'd1, 8'h42, 8'h03, 1'b1, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd2, 8'h00, 8'h00, 1'b1, 2'd1, 18'd4,  8'd3, 18'd0,  8'd0},
    '{MODE_CELL,  2'd1, 8'h00, 8'h00, 1'b0, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd3, 8'h00, 8'h00, 1'b0, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd0, 8'h00, 8'h00, 1'b1, 2'd1, 18'd7,  8'd1, 18'd0,  8'd0},
    '{MODE_CELL,  2'd1, 8'h00, 8'h00, 1'b1, 2'd2, 18'd8,  8'd2, 18'd12, 8'd1},
    '{MODE_CELL,  2'd2, 8'h00, 8'h00, 1'b0, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd0, 8'h00, 8'h00, 1'b0, 2'd0, 18'd0,  8'd0, 18'd0,  8'd0},
    '{MODE_CELL,  2'd3, 8'h00, 8'h00, 1'b1, 2'd2, 18'd11, 8'd0, 18'd15, 8'd3}
  };

  localparam phase_t PHASES [N_PHASE] = '{
    '{REG_MAP_WIDTH,  13'd1,    REG_MAP_HEIGHT, 13'h1FFF, 9'd20, 1'b0, 1'b0},
    '{REG_MAP_WIDTH,  13'd0,    REG_MAP_HEIGHT, 13'd0,    9'd24, 1'b0, 1'b0},
    '{REG_MAP_HEIGHT, 13'd4096, REG_MAP_WIDTH,  13'd64,   9'd90, 1'b1, 1'b0},
    '{REG_MAP_WIDTH,  13'h1F85, REG_MAP_HEIGHT, 13'd1,    9'd20, 1'b0, 1'b0},
    '{REG_MAP_WIDTH,  13'd127,  REG_MAP_HEIGHT, 13'd2,    9'd70, 1'b0, 1'b0},
    '{REG_SPARE_A,    13'h1FFF, REG_SPARE_B,    13'h0AAA, 9'd30, 1'b0, 1'b0},
    '{REG_MAP_WIDTH,  13'd5,    REG_MAP_HEIGHT, 13'd4,    9'd80, 1'b0, 1'b0},
    '{REG_MAP_WIDTH,  13'd3,    REG_MAP_HEIGHT, 13'd3,    9'd60, 1'b0, 1'b1}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // terrain, table_index, table_value
  logic                  s_axis_tuser;   // mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // cell_index, tile
  logic                  m_axis_tlast;   // last_of_item
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  neighbour_key_autotiler dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // model state
  logic [CFG_W_W-1:0] map_w = CFG_W_W'(64);
  logic [CFG_H_W-1:0] map_h = CFG_H_W'(64);
  logic [TYPE_W-1:0]  row_store [2*MAX_WIDTH] = '{default: '0};
  logic               wide_flag [MAX_WIDTH] = '{default: 1'b0};
  logic [TILE_W-1:0]  tile_lut [LUT_DEPTH] = '{default: '0};
  int unsigned        col_cnt = 0;
  int unsigned        row_cnt = 0;

  out_word_t pending_tiles [$];
  out_word_t next_tiles [2];
  int        next_count;
  out_word_t seen_tile;

  int   err_count = 0;
  int   cycles = 0;
  bit   no_idle = 1'b0;
  bit   hold_req = 1'b0;
  int   stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic predict_tiles(input mode_t md, input logic [TYPE_W-1:0] ter,
                               input logic [KEY_W-1:0] kidx, input logic [TILE_W-1:0] kval);
    int unsigned w, h, c, r, cur, prv;
    logic [TILE_W-1:0] tile;
    logic [KEY_W-1:0]  key;
    logic              on_border;
    next_count = 0;
    if (md == MODE_TABLE) begin
      tile_lut[kidx] = kval;
      return;
    end
    w = (map_w == 0) ? 1 : ((map_w > MAX_WIDTH) ? MAX_WIDTH : map_w);
    h = (map_h == 0) ? 1 : ((map_h > HEIGHT_LIMIT) ? HEIGHT_LIMIT : map_h);
    c = (col_cnt >= w) ? 0 : col_cnt;
    r = (row_cnt >= h) ? 0 : row_cnt;
    cur = (r % 2) * MAX_WIDTH;
    prv = ((r % 2) ^ 1) * MAX_WIDTH;
    if (r >= 1) begin
      tile = TILE_W'(row_store[prv + c]);
      on_border = (r == 1) || (c == 0) || (c == w - 1);
      if (!on_border && !wide_flag[c] && !wide_flag[c - 1]) begin
        key = {row_store[prv + c - 1], ter, row_store[prv + c + 1], row_store[cur + c]};
        tile = tile_lut[key];
      end
      wide_flag[c] = (tile > WIDE_LIMIT);
      next_tiles[next_count] = '{IDX_W'((r - 1) * w + c), tile, 1'b0};
      next_count++;
    end
    row_store[cur + c] = ter;
    if (r == h - 1) begin
      next_tiles[next_count] = '{IDX_W'(r * w + c), TILE_W'(ter), 1'b0};
      next_count++;
    end
    if (next_count > 0) next_tiles[next_count - 1].last = 1'b1;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  task automatic write_pair(input logic [CFG_IDX_W-1:0] ia, input logic [CFG_DATA_W-1:0] da,
                            input logic [CFG_IDX_W-1:0] ib, input logic [CFG_DATA_W-1:0] db);
    logic [CFG_IDX_W-1:0]  wi [2];
    logic [CFG_DATA_W-1:0] wd [2];
    wi[0] = ia;
    wi[1] = ib;
    wd[0] = da;
    wd[1] = db;
    for (int k = 0; k < 2; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= wi[k];
      cfg_data  <= wd[k];
      @(posedge clk);
      case (wi[k])
        REG_MAP_WIDTH: begin
          map_w = wd[k][CFG_W_W-1:0];
          col_cnt = 0;
          row_cnt = 0;
        end
        REG_MAP_HEIGHT: begin
          map_h = wd[k][CFG_H_W-1:0];
          col_cnt = 0;
          row_cnt = 0;
        end
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic offer_word(input mode_t md, input logic [TYPE_W-1:0] ter,
                            input logic [KEY_W-1:0] kidx, input logic [TILE_W-1:0] kval);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= md;
    s_axis_tdata  <= IN_DATA_W'({kval, kidx, ter});
    do @(posedge clk); while (!s_axis_tready);
    predict_tiles(md, ter, kidx, kval);
  endtask

  task automatic settle_out();
    s_axis_tvalid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 16);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_tiles.size() == 0) begin
        $error("unexpected word: cell_index %0d tile %0d last_of_item %0b",
               m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W +: TILE_W], m_axis_tlast);
        err_count++;
      end else begin
        seen_tile = pending_tiles.pop_front();
        if (m_axis_tdata[IDX_W-1:0] !== seen_tile.idx) begin
          $error("cell_index: expected %0d, got %0d", seen_tile.idx, m_axis_tdata[IDX_W-1:0]);
          err_count++;
        end
        if (m_axis_tdata[IDX_W +: TILE_W] !== seen_tile.tile) begin
          $error("tile: expected %0d, got %0d (cell %0d)", seen_tile.tile,
                 m_axis_tdata[IDX_W +: TILE_W], seen_tile.idx);
          err_count++;
        end
        if (m_axis_tlast !== seen_tile.last) begin
          $error("last_of_item: expected %0b, got %0b (cell %0d)", seen_tile.last,
                 m_axis_tlast, seen_tile.idx);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    mode_t md;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_CELL;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_MAP_WIDTH;
    cfg_data      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_pair(REG_MAP_WIDTH, 13'd4, REG_MAP_HEIGHT, 13'd4);
    foreach (DIR_ROWS[i]) begin
      offer_word(DIR_ROWS[i].md, DIR_ROWS[i].ter, DIR_ROWS[i].kidx, DIR_ROWS[i].kval);
      if (DIR_ROWS[i].typed) begin
        if (DIR_ROWS[i].nres >= 1)
          pending_tiles.push_back('{DIR_ROWS[i].i0, DIR_ROWS[i].t0, DIR_ROWS[i].nres == 1});
        if (DIR_ROWS[i].nres == 2)
          pending_tiles.push_back('{DIR_ROWS[i].i1, DIR_ROWS[i].t1, 1'b1});
      end else begin
        for (int k = 0; k < next_count; k++) pending_tiles.push_back(next_tiles[k]);
      end
    end
    settle_out();

    foreach (PHASES[p]) begin
      write_pair(PHASES[p].ia, PHASES[p].da, PHASES[p].ib, PHASES[p].db);
      no_idle = PHASES[p].quiet;
      if (PHASES[p].squeeze) hold_req = 1'b1;
      for (int k = 0; k < PHASES[p].items; k++) begin
        md = ($urandom_range(0, 4) == 0) ? MODE_TABLE : MODE_CELL;
        offer_word(md, TYPE_W'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 255)),
                   $urandom_range(0, 1) ? TILE_W'($urandom_range(0, 3))
                                        : TILE_W'($urandom_range(0, 255)));
        for (int j = 0; j < next_count; j++) pending_tiles.push_back(next_tiles[j]);
      end
      settle_out();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== neighbour_key_autotiler.f =====
rtl/core/nka_pkg.sv
rtl/core/nka_line_store.sv
rtl/core/nka_tile_lut.sv
rtl/core/nka_out_buf.sv
rtl/core/neighbour_key_autotiler.sv
verif/tb_top.sv
